// ===== src/assert_macros.svh =====
// Assertion macros used by the checker module of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked on every clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sccws_pkg.sv =====
// Package for the comment and whitespace stripper: scan modes, character
// constants, step result struct and character class helpers. No dependencies.
`timescale 1ns / 1ps

package sccws_pkg;

    typedef enum logic [2:0] {
        MODE_NORMAL     = 3'd0,
        MODE_SPACE      = 3'd1,
        MODE_STRING     = 3'd2,
        MODE_SLASH      = 3'd3,
        MODE_LINE       = 3'd4,
        MODE_BLOCK      = 3'd5,
        MODE_BLOCK_STAR = 3'd6
    } scan_mode_t;

    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_STAR    = 8'h2A;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_QUOTE   = 8'h22;

    // Results of one step: up to two bytes, count 0..2.
    typedef struct packed {
        scan_mode_t  mode_next;
        logic [7:0]  prev_next;
        logic [1:0]  count;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
    } step_result_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

endpackage

// ===== src/sccws_step.sv =====
// Combinational scan step: next mode, remembered character and emitted bytes.
// Depends on sccws_pkg.
`timescale 1ns / 1ps

module sccws_step
    import sccws_pkg::*;
(
    input  scan_mode_t   mode,
    input  logic [7:0]   prev_char,
    input  logic [7:0]   in_char,
    input  logic         end_of_text,
    input  logic         strip_enable,
    output step_result_t result
);

    // Plain-text handling of the current byte
    scan_mode_t plain_mode;
    logic       plain_emit;
    logic       plain_prev;

    always_comb
    begin
        plain_emit = 1'b0;
        plain_prev = 1'b0;
        if (is_blank(in_char))
        begin
            plain_mode = MODE_SPACE;
        end
        else if (in_char == CHAR_QUOTE)
        begin
            plain_mode = MODE_STRING;
            plain_emit = 1'b1;
        end
        else if (in_char == CHAR_SLASH)
        begin
            plain_mode = MODE_SLASH;
        end
        else
        begin
            plain_mode = MODE_NORMAL;
            plain_emit = 1'b1;
            plain_prev = 1'b1;
        end
    end

    logic       pre_emit;
    logic [7:0] pre_byte;
    logic       main_emit;

    always_comb
    begin
        result.mode_next = mode;
        result.prev_next = prev_char;
        pre_emit         = 1'b0;
        pre_byte         = CHAR_SPACE;
        main_emit        = 1'b0;

        if (end_of_text)
        begin
            result.mode_next = MODE_NORMAL;
            result.prev_next = 8'd0;
        end
        else if (!strip_enable)
        begin
            main_emit = 1'b1;
        end
        else
        begin
            case (mode)
                MODE_SPACE:
                begin
                    if (!is_blank(in_char))
                    begin
                        pre_emit         = is_word(prev_char) && is_word(in_char);
                        main_emit        = plain_emit;
                        result.mode_next = plain_mode;
                        if (plain_prev)
                            result.prev_next = in_char;
                    end
                end
                MODE_STRING:
                begin
                    main_emit = 1'b1;
                    if (in_char == CHAR_QUOTE)
                    begin
                        result.prev_next = in_char;
                        result.mode_next = MODE_NORMAL;
                    end
                end
                MODE_SLASH:
                begin
                    if (in_char == CHAR_SLASH)
                        result.mode_next = MODE_LINE;
                    else if (in_char == CHAR_STAR)
                        result.mode_next = MODE_BLOCK;
                    else
                    begin
                        // lone slash: emit it, then treat the byte as text
                        pre_emit         = 1'b1;
                        pre_byte         = CHAR_SLASH;
                        main_emit        = plain_emit;
                        result.mode_next = plain_mode;
                        result.prev_next = plain_prev ? in_char : CHAR_SLASH;
                    end
                end
                MODE_LINE:
                begin
                    if (in_char == CHAR_NEWLINE)
                    begin
                        result.prev_next = in_char;
                        result.mode_next = MODE_NORMAL;
                    end
                end
                MODE_BLOCK:
                begin
                    if (in_char == CHAR_STAR)
                        result.mode_next = MODE_BLOCK_STAR;
                end
                MODE_BLOCK_STAR:
                begin
                    if (in_char == CHAR_SLASH)
                    begin
                        result.prev_next = in_char;
                        result.mode_next = MODE_NORMAL;
                    end
                    else if (in_char != CHAR_STAR)
                        result.mode_next = MODE_BLOCK;
                end
                default:
                begin
                    main_emit        = plain_emit;
                    result.mode_next = plain_mode;
                    if (plain_prev)
                        result.prev_next = in_char;
                end
            endcase
        end

        result.count = {1'b0, pre_emit} + {1'b0, main_emit};
        result.byte0 = pre_emit ? pre_byte : in_char;
        result.byte1 = in_char;
    end

endmodule

// ===== src/sccws_obuf.sv =====
// Result buffer: holds the one or two bytes of a step and drains them in
// order on the output channel. Depends on sccws_pkg.
`timescale 1ns / 1ps

module sccws_obuf
    import sccws_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  step_result_t push_data,
    output logic         can_push,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [7:0]   out_char,
    output logic         last
);

    logic       full_reg,  full_next;
    logic       two_reg,   two_next;
    logic       sel_reg,   sel_next;
    logic [7:0] byte0_reg, byte0_next;
    logic [7:0] byte1_reg, byte1_next;
    logic       pop_last;

    assign out_valid = full_reg;
    assign out_char  = sel_reg ? byte1_reg : byte0_reg;
    assign last      = sel_reg || !two_reg;
    assign pop_last  = full_reg && out_ready && last;
    assign can_push  = !full_reg || pop_last;

    always_comb
    begin
        full_next  = full_reg;
        two_next   = two_reg;
        sel_next   = sel_reg;
        byte0_next = byte0_reg;
        byte1_next = byte1_reg;
        if (full_reg && out_ready)
        begin
            // advance to the second byte, or drop the finished pair
            if (last)
                full_next = 1'b0;
            else
                sel_next = 1'b1;
        end
        if (push)
        begin
            full_next  = 1'b1;
            two_next   = push_data.count[1];
            sel_next   = 1'b0;
            byte0_next = push_data.byte0;
            byte1_next = push_data.byte1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            two_reg  <= 1'b0;
            sel_reg  <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
            two_reg  <= two_next;
            sel_reg  <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte0_reg <= byte0_next;
        byte1_reg <= byte1_next;
    end

endmodule

// ===== src/source_comment_whitespace_stripper.sv =====
// An accepted item passes the input register, then the result buffer, before
// its first result shows. Throughput: one item per cycle while the result
// buffer takes each result; a two-byte item holds it until both bytes are out.
// Reset (rst_n, async low): scan mode normal, remembered character zero,
// stripping enabled, input and result registers empty.
// Depends on sccws_pkg, sccws_step and sccws_obuf.
`timescale 1ns / 1ps

module source_comment_whitespace_stripper
    import sccws_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // configuration write channel: strip_enable
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    // input item channel
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_char,
    input  logic       end_of_text,
    // result item channel
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       last
);

    // Configuration register: the write is always taken at once.
    logic strip_enable_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strip_enable_reg <= 1'b1;
        else if (cfg_valid && cfg_ready)
            strip_enable_reg <= cfg_data;
    end

    // Input register: holds one accepted item until the step can retire it.
    logic       in_full_reg;
    logic [7:0] char_reg;
    logic       eot_reg;

    // Scan state, updated only when an item retires so results stay in order.
    scan_mode_t mode_reg;
    logic [7:0] prev_reg;

    step_result_t step;
    logic         can_push;
    logic         needs_push;
    logic         advance;

    sccws_step u_step (
        .mode         (mode_reg),
        .prev_char    (prev_reg),
        .in_char      (char_reg),
        .end_of_text  (eot_reg),
        .strip_enable (strip_enable_reg),
        .result       (step)
    );

    // An item that emits nothing retires without touching the result buffer.
    assign needs_push = (step.count != 2'd0);
    assign advance    = in_full_reg && (!needs_push || can_push);
    assign in_ready   = !in_full_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
            mode_reg    <= MODE_NORMAL;
            prev_reg    <= 8'd0;
        end
        else
        begin
            if (in_ready)
                in_full_reg <= in_valid;
            if (advance)
            begin
                mode_reg <= step.mode_next;
                prev_reg <= step.prev_next;
            end
        end
    end

    // Payload of the input register needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg <= in_char;
            eot_reg  <= end_of_text;
        end
    end

    sccws_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance && needs_push),
        .push_data (step),
        .can_push  (can_push),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .last      (last)
    );

endmodule

// ===== src/sccws_checker.sv =====
// Port-level checker for source_comment_whitespace_stripper, bound to it.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sccws_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_char,
    input logic       last
);

    // a stalled result holds its payload
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_char) && $stable(last), "stalled result changed")
    // the first byte of a pair is always followed by a valid result byte
    `ASSERT_NEXT(a_pair_follows, clk, rst_n, out_valid && !last, out_valid, "pair broken")
    // a pair has at most two bytes: a taken first byte is followed by the final one
    `ASSERT_NEXT(a_pair_len, clk, rst_n, out_valid && out_ready && !last, out_valid && last, "more than two results")
    // input stalls only behind a waiting result
    `ASSERT_IMPL(a_stall_cause, clk, rst_n, !in_ready, out_valid, "input stalled with empty output")

endmodule

bind source_comment_whitespace_stripper sccws_checker u_sccws_checker (.*);
